// ===== sv/tpps_pkg.sv =====
// Package for the three-point percentile selector.
// Payload structs, configuration codes, state enums and key helpers.
// No dependencies.
package tpps_pkg;

	localparam int unsigned MAX_SAMPLES = 65536;
	localparam int unsigned ADDR_W = $clog2(MAX_SAMPLES);
	localparam int unsigned CNT_W = ADDR_W + 1;
	localparam int unsigned FRAC_W = 17;
	localparam int unsigned BIT_W = 5;

	localparam logic [1:0] CFG_LOW = 2'd0;
	localparam logic [1:0] CFG_MID = 2'd1;
	localparam logic [1:0] CFG_HIGH = 2'd2;

	typedef struct packed {
		logic [31:0] sample_bits;
		logic last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] low_value;
		logic [31:0] mid_value;
		logic [31:0] high_value;
		logic [16:0] kept_count;
		logic empty_res;
		logic overflow;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic [CNT_W-1:0] count;
		logic [FRAC_W-1:0] low_frac;
		logic [FRAC_W-1:0] mid_frac;
		logic [FRAC_W-1:0] high_frac;
	} sel_req_t;

	typedef struct packed {
		logic done;
		logic [31:0] low_value;
		logic [31:0] mid_value;
		logic [31:0] high_value;
	} sel_rsp_t;

	typedef enum logic [1:0] {
		TOP_LOAD,
		TOP_SEL,
		TOP_DONE
	} top_state_t;

	typedef enum logic [2:0] {
		SEL_IDLE,
		SEL_RANK,
		SEL_READ,
		SEL_DRAIN,
		SEL_UPDATE
	} sel_state_t;

	function automatic logic [31:0] to_key(input logic [31:0] bits);
		return bits[31] ? ~bits : (bits | 32'h8000_0000);
	endfunction

	function automatic logic [31:0] from_key(input logic [31:0] key);
		return key[31] ? (key & 32'h7FFF_FFFF) : ~key;
	endfunction

endpackage

// ===== sv/tpps_store.sv =====
// Sample memory: one write port, one read port with registered data.
// Depends on tpps_pkg.
module tpps_store (
	input  logic clk,
	input  logic wr_en,
	input  logic [tpps_pkg::ADDR_W-1:0] wr_addr,
	input  logic [31:0] wr_data,
	input  logic rd_en,
	input  logic [tpps_pkg::ADDR_W-1:0] rd_addr,
	output logic [31:0] rd_data
);
	import tpps_pkg::*;

	logic [31:0] mem [MAX_SAMPLES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== sv/tpps_select.sv =====
// Radix selection engine: one memory scan per key bit, three ranks at once.
// Depends on tpps_pkg; reads the sample memory through its read port.
module tpps_select (
	input  logic clk,
	input  logic arst_n,
	input  tpps_pkg::sel_req_t req,
	output tpps_pkg::sel_rsp_t rsp,
	output logic rd_en,
	output logic [tpps_pkg::ADDR_W-1:0] rd_addr,
	input  logic [31:0] rd_data
);
	import tpps_pkg::*;

	sel_state_t state_q, state_d;
	logic [CNT_W-1:0] n_q;
	logic [ADDR_W-1:0] addr_q;
	logic [BIT_W-1:0] bit_q;
	logic rvalid_s1;
	logic [ADDR_W-1:0] k_q [3];
	logic [CNT_W-1:0] c_q [3];
	logic [31:0] pfx_q [3];
	logic [FRAC_W-1:0] frac_q [3];
	logic [ADDR_W-1:0] last_addr;
	logic [31:0] hi_mask;
	logic [31:0] key;

	assign last_addr = ADDR_W'(n_q - CNT_W'(1));
	assign hi_mask = 32'hFFFF_FFFE << bit_q;
	assign key = to_key(rd_data);

	assign rd_en = (state_q == SEL_READ);
	assign rd_addr = addr_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			SEL_IDLE: if (req.start) state_d = SEL_RANK;
			SEL_RANK: state_d = SEL_READ;
			SEL_READ: if (addr_q == last_addr) state_d = SEL_DRAIN;
			SEL_DRAIN: state_d = SEL_UPDATE;
			SEL_UPDATE: state_d = (bit_q == '0) ? SEL_IDLE : SEL_READ;
			default: state_d = SEL_IDLE;
		endcase
	end

	always_comb begin
		rsp.done = (state_q == SEL_UPDATE) && (bit_q == '0);
		rsp.low_value = from_key(pfx_q[0]);
		rsp.mid_value = from_key(pfx_q[1]);
		rsp.high_value = from_key(pfx_q[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEL_IDLE;
			rvalid_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			rvalid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SEL_IDLE: begin
				if (req.start) begin
					n_q <= req.count;
					frac_q[0] <= req.low_frac;
					frac_q[1] <= req.mid_frac;
					frac_q[2] <= req.high_frac;
				end
			end
			SEL_RANK: begin
				addr_q <= '0;
				bit_q <= BIT_W'(31);
				for (int r = 0; r < 3; r++) begin
					logic [2*CNT_W-1:0] prod;
					logic [CNT_W+1:0] kk;
					prod = (2*CNT_W)'(frac_q[r]) * (2*CNT_W)'(n_q);
					kk = (CNT_W+2)'(prod[2*CNT_W-1:16]);
					k_q[r] <= (kk > (CNT_W+2)'(n_q - CNT_W'(1))) ? last_addr
						: ADDR_W'(kk);
					c_q[r] <= '0;
					pfx_q[r] <= '0;
				end
			end
			SEL_UPDATE: begin
				addr_q <= '0;
				bit_q <= bit_q - BIT_W'(1);
				for (int r = 0; r < 3; r++) begin
					c_q[r] <= '0;
					// at most k keys fall under a zero here: the bit is one
					if (CNT_W'(k_q[r]) >= c_q[r]) begin
						pfx_q[r][bit_q] <= 1'b1;
						k_q[r] <= k_q[r] - ADDR_W'(c_q[r]);
					end
				end
			end
			default: begin
				if (state_q == SEL_READ) begin
					addr_q <= addr_q + ADDR_W'(1);
				end
			end
		endcase
		if (rvalid_s1) begin
			for (int r = 0; r < 3; r++) begin
				if ((((key ^ pfx_q[r]) & hi_mask) == '0) && !key[bit_q]) begin
					c_q[r] <= c_q[r] + CNT_W'(1);
				end
			end
		end
	end

endmodule

// ===== sv/three_point_percentile_selector.sv =====
// Three-point percentile selector: load samples at one per cycle, then select.
// Selection makes one memory scan per key bit through the single read port;
// an empty set skips selection and goes straight to the result.
// Throughput: one sample per cycle while loading; no input during selection.
// Reset: asynchronous, active low; clears count and flags, loads default fractions.
module three_point_percentile_selector (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  tpps_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output tpps_pkg::out_item_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [16:0] cfg_data
);
	import tpps_pkg::*;

	top_state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic ovf_q;
	logic empty_q;
	logic [FRAC_W-1:0] low_frac_q, mid_frac_q, high_frac_q;
	logic out_valid_q;
	out_item_t out_q;

	logic in_fire, finite, has_room, wr_en;
	logic [CNT_W-1:0] n_next;
	logic out_free;
	sel_req_t req;
	sel_rsp_t rsp;
	logic rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [31:0] rd_data;

	assign in_ready = (state_q == TOP_LOAD);
	assign in_fire = in_valid && in_ready;
	assign finite = (in_data.sample_bits[30:23] != 8'hFF);
	assign has_room = (count_q < CNT_W'(MAX_SAMPLES));
	assign wr_en = in_fire && finite && has_room;
	assign n_next = count_q + CNT_W'(wr_en);
	assign out_free = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		req.start = in_fire && in_data.last && (n_next != '0);
		req.count = n_next;
		req.low_frac = low_frac_q;
		req.mid_frac = mid_frac_q;
		req.high_frac = high_frac_q;
	end

	tpps_store u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(count_q[ADDR_W-1:0]),
		.wr_data(in_data.sample_bits),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	tpps_select u_select (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			TOP_LOAD: begin
				if (in_fire && in_data.last) begin
					state_d = (n_next == '0) ? TOP_DONE : TOP_SEL;
				end
			end
			TOP_SEL: if (rsp.done) state_d = TOP_DONE;
			TOP_DONE: if (out_free) state_d = TOP_LOAD;
			default: state_d = TOP_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TOP_LOAD;
			count_q <= '0;
			ovf_q <= 1'b0;
			empty_q <= 1'b0;
			out_valid_q <= 1'b0;
			low_frac_q <= FRAC_W'(16384);
			mid_frac_q <= FRAC_W'(32768);
			high_frac_q <= FRAC_W'(49152);
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LOW: low_frac_q <= cfg_data;
					CFG_MID: mid_frac_q <= cfg_data;
					CFG_HIGH: high_frac_q <= cfg_data;
					default: ;
				endcase
			end
			if (wr_en) begin
				count_q <= n_next;
			end
			if (in_fire && finite && !has_room) begin
				ovf_q <= 1'b1;
			end
			if (in_fire && in_data.last) begin
				empty_q <= (n_next == '0);
			end
			if (state_q == TOP_DONE && out_free) begin
				out_valid_q <= 1'b1;
				count_q <= '0;
				ovf_q <= 1'b0;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == TOP_DONE && out_free) begin
			out_q.low_value <= empty_q ? 32'd0 : rsp.low_value;
			out_q.mid_value <= empty_q ? 32'd0 : rsp.mid_value;
			out_q.high_value <= empty_q ? 32'd0 : rsp.high_value;
			out_q.kept_count <= count_q;
			out_q.empty_res <= empty_q;
			out_q.overflow <= ovf_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count past capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (count_q == CNT_W'(MAX_SAMPLES)))
		else $error("overflow flagged with room left");

	a_done_in_sel: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == TOP_SEL))
		else $error("selection finished outside select phase");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("memory written during a scan");
`endif

endmodule
